### rtl/core/spc_pkg.sv
// Shared types and codes for the steering pulse controller.
package spc_pkg;

    typedef enum logic [1:0] {
        OP_TICK  = 2'd0,
        OP_LEFT  = 2'd1,
        OP_RIGHT = 2'd2,
        OP_STOP  = 2'd3
    } op_t;

    typedef enum logic [1:0] {
        MODE_IDLE     = 2'd0,
        MODE_PULSING  = 2'd1,
        MODE_COOLDOWN = 2'd2
    } mode_t;

    typedef enum logic [1:0] {
        DIR_NONE  = 2'd0,
        DIR_LEFT  = 2'd1,
        DIR_RIGHT = 2'd2
    } dir_t;

    typedef enum logic [1:0] {
        MOTOR_COAST   = 2'd0,
        MOTOR_FORWARD = 2'd1,
        MOTOR_REVERSE = 2'd2
    } motor_t;

    localparam logic [1:0] CFG_PULSE_TIME    = 2'd0;
    localparam logic [1:0] CFG_COOLDOWN_TIME = 2'd1;
    localparam logic [1:0] CFG_DEFAULT_DUTY  = 2'd2;
    localparam logic [1:0] CFG_INVERT        = 2'd3;

    localparam int CFG_DATA_W = 16;
    localparam int CFG_IDX_W  = 2;
    localparam int IN_DATA_W  = 8;
    localparam int OUT_DATA_W = 16;

    localparam logic [15:0] TICK_MAX = 16'hFFFF;

    typedef struct packed {
        logic [15:0] pulse_time;
        logic [15:0] cooldown_time;
        logic [7:0]  default_duty;
        logic        invert_polarity;
    } cfg_t;

    typedef struct packed {
        logic [1:0] previous_direction;
        logic       accepted;
        logic [1:0] mode;
        logic       drive_written;
        logic [7:0] drive_duty;
        logic [1:0] drive_direction;
    } result_t;

endpackage

### rtl/core/spc_cfg_regs.sv
// Configuration register bank for the steering pulse controller.
module spc_cfg_regs
    import spc_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    output cfg_t                  cfg
);

    cfg_t cfg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.pulse_time      <= 16'd100;
            cfg_reg.cooldown_time   <= 16'd50;
            cfg_reg.default_duty    <= 8'd255;
            cfg_reg.invert_polarity <= 1'b0;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_PULSE_TIME:    cfg_reg.pulse_time      <= cfg_data;
                CFG_COOLDOWN_TIME: cfg_reg.cooldown_time   <= cfg_data;
                CFG_DEFAULT_DUTY:  cfg_reg.default_duty    <= cfg_data[7:0];
                CFG_INVERT:        cfg_reg.invert_polarity <= cfg_data[0];
                default:           cfg_reg                 <= cfg_reg;
            endcase
        end
    end

    assign cfg = cfg_reg;

endmodule

### rtl/core/spc_fsm.sv
// Mode state machine, pulse timer and motor drive state.
module spc_fsm
    import spc_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       advance,
    input  op_t        op,
    input  logic [7:0] speed,
    input  cfg_t       cfg,
    output result_t    result
);

    mode_t       mode_reg, mode_next;
    dir_t        active_dir_reg, active_dir_next;
    dir_t        last_dir_reg, last_dir_next;
    logic [15:0] elapsed_reg, elapsed_next;
    motor_t      drive_dir_reg, drive_dir_next;
    logic [7:0]  drive_duty_reg, drive_duty_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg       <= MODE_IDLE;
            active_dir_reg <= DIR_NONE;
            last_dir_reg   <= DIR_NONE;
            elapsed_reg    <= 16'd0;
            drive_dir_reg  <= MOTOR_COAST;
            drive_duty_reg <= 8'd0;
        end
        else if (advance)
        begin
            mode_reg       <= mode_next;
            active_dir_reg <= active_dir_next;
            last_dir_reg   <= last_dir_next;
            elapsed_reg    <= elapsed_next;
            drive_dir_reg  <= drive_dir_next;
            drive_duty_reg <= drive_duty_next;
        end
    end

    always_comb
    begin
        dir_t        req_dir;
        logic [7:0]  duty;
        logic [15:0] elapsed_inc;
        logic        phys_left;
        logic        written;
        logic        accepted;

        mode_next       = mode_reg;
        active_dir_next = active_dir_reg;
        last_dir_next   = last_dir_reg;
        elapsed_next    = elapsed_reg;
        drive_dir_next  = drive_dir_reg;
        drive_duty_next = drive_duty_reg;
        written         = 1'b0;
        accepted        = 1'b0;

        req_dir     = (op == OP_LEFT) ? DIR_LEFT : DIR_RIGHT;
        duty        = (speed == 8'd0) ? cfg.default_duty : speed;
        phys_left   = (op == OP_LEFT) ^ cfg.invert_polarity;
        elapsed_inc = (elapsed_reg == TICK_MAX) ? elapsed_reg : elapsed_reg + 16'd1;

        unique case (op)
            OP_LEFT, OP_RIGHT:
            begin
                accepted     = 1'b1;
                elapsed_next = 16'd0;
                if (!(mode_reg == MODE_PULSING && active_dir_reg == req_dir))
                begin
                    drive_dir_next  = phys_left ? MOTOR_REVERSE : MOTOR_FORWARD;
                    drive_duty_next = duty;
                    written         = 1'b1;
                    mode_next       = MODE_PULSING;
                    active_dir_next = req_dir;
                end
            end
            OP_STOP:
            begin
                drive_dir_next  = MOTOR_COAST;
                drive_duty_next = 8'd0;
                written         = 1'b1;
                active_dir_next = DIR_NONE;
                if (mode_reg == MODE_PULSING)
                begin
                    last_dir_next = active_dir_reg;
                    mode_next     = MODE_COOLDOWN;
                    elapsed_next  = 16'd0;
                end
                else
                begin
                    mode_next = MODE_IDLE;
                end
            end
            default:
            begin
                // Tick: advance the timer only while a pulse or cooldown runs.
                if (mode_reg == MODE_PULSING)
                begin
                    elapsed_next = elapsed_inc;
                    if (elapsed_inc >= cfg.pulse_time)
                    begin
                        drive_dir_next  = MOTOR_COAST;
                        drive_duty_next = 8'd0;
                        written         = 1'b1;
                        last_dir_next   = active_dir_reg;
                        active_dir_next = DIR_NONE;
                        mode_next       = MODE_COOLDOWN;
                        elapsed_next    = 16'd0;
                    end
                end
                else if (mode_reg == MODE_COOLDOWN)
                begin
                    elapsed_next = elapsed_inc;
                    if (elapsed_inc >= cfg.cooldown_time)
                    begin
                        mode_next = MODE_IDLE;
                    end
                end
            end
        endcase

        result.drive_direction    = drive_dir_next;
        result.drive_duty         = drive_duty_next;
        result.drive_written      = written;
        result.mode               = mode_next;
        result.accepted           = accepted;
        result.previous_direction = last_dir_next;
    end

    // A pulse in progress always owns a direction, and no other mode does.
    a_active_dir: assert property (@(posedge clk) disable iff (!rst_n)
        (mode_reg == MODE_PULSING) == (active_dir_reg != DIR_NONE))
        else $error("active direction out of step with mode");

    // Outside a pulse the motor coasts at zero duty.
    a_coast_outside_pulse: assert property (@(posedge clk) disable iff (!rst_n)
        (mode_reg != MODE_PULSING) |-> (drive_dir_reg == MOTOR_COAST && drive_duty_reg == 8'd0))
        else $error("motor driven outside a pulse");

    // A stop request leaves the motor coasting.
    a_stop_coasts: assert property (@(posedge clk) disable iff (!rst_n)
        (advance && op == OP_STOP) |=> (drive_dir_reg == MOTOR_COAST && mode_reg != MODE_PULSING))
        else $error("stop did not coast the motor");

endmodule

### rtl/core/steering_pulse_controller.sv
// Top level of the steering pulse controller: stream ports, input and result registers.
//
// The controller turns a stream of requests (millisecond ticks, left or right pulse
// requests and stop requests) into one result per request that reports the motor drive,
// the mode and the last pulsed direction. Each request is captured in an input register,
// processed by the mode state machine, and its result lands in a result register; with
// the result side ready, one request is taken every clock cycle. The input register frees
// up while a result waits, so one more request is taken before the inputs stall. The user
// must write configuration through the plain write port only while no request is in
// flight; the block does not enforce this. Register 0 is the pulse length, 1 the cooldown
// length, 2 the default duty and 3 the polarity swap.
module steering_pulse_controller
    import spc_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    // configuration write port
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    // request stream
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [IN_DATA_W-1:0]  s_tdata,   // [7:0] speed
    input  logic [1:0]            s_tuser,   // [1:0] op
    // result stream
    output logic                  m_tvalid,
    input  logic                  m_tready,
    // [1:0] drive_direction, [9:2] drive_duty, [10] drive_written,
    // [12:11] mode, [13] accepted, [15:14] previous_direction
    output logic [OUT_DATA_W-1:0] m_tdata
);

    cfg_t    cfg;
    result_t result;

    logic                 in_valid_reg;
    logic [1:0]           in_op_reg;
    logic [IN_DATA_W-1:0] in_speed_reg;
    logic                 out_valid_reg;
    result_t              out_data_reg;
    logic                 advance;

    spc_cfg_regs u_cfg_regs (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    // Move the held request into the result register when that register is free.
    assign advance  = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || advance;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (s_tready)
        begin
            in_valid_reg <= s_tvalid;
        end
    end

    // Payload: hold while stalled, capture on acceptance.
    always_ff @(posedge clk)
    begin
        if (s_tvalid && s_tready)
        begin
            in_op_reg    <= s_tuser;
            in_speed_reg <= s_tdata;
        end
    end

    spc_fsm u_fsm (
        .clk     (clk),
        .rst_n   (rst_n),
        .advance (advance),
        .op      (op_t'(in_op_reg)),
        .speed   (in_speed_reg),
        .cfg     (cfg),
        .result  (result)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (m_tready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            out_data_reg <= result;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;

endmodule
